// ----- rtl/min_cost_bipartite_assignment_macros.svh -----
// Assertion macros for the assignment solver checker.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef MIN_COST_BIPARTITE_ASSIGNMENT_MACROS_SVH
`define MIN_COST_BIPARTITE_ASSIGNMENT_MACROS_SVH

// Same-cycle implication.
`define MCBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcba check failed");

// Next-cycle implication.
`define MCBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcba check failed");

`endif

// ----- rtl/mcba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcba_pkg
// Shared constants, state and arc codes, and the result record of the
// min-cost bipartite assignment solver.
// ----------------------------------------------------------------------------
package mcba_pkg;

  localparam int DEF_MAX_WORKERS = 16;
  localparam int DEF_MAX_JOBS    = 16;
  localparam int DEF_MAX_EDGES   = 256;
  localparam int DEF_COST_WIDTH  = 32;

  localparam int IDX_IN_W    = 4;
  localparam int WEIGHT_IN_W = 32;
  localparam int TOTAL_W     = 48;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_WORKER_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_JOB_COUNT    = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  CFG_COUNT_RESET  = 5'd1;

  // Residual arc classes: source->worker, worker->job, job->worker, job->sink
  typedef enum logic [1:0] {
    ARC_SRC,
    ARC_FWD,
    ARC_REV,
    ARC_SNK
  } arc_kind_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_BF,
    ST_ARC_RD,
    ST_ARC_NODE,
    ST_ARC_EVAL,
    ST_CHECK,
    ST_ADD,
    ST_WALK_RD,
    ST_WALK_ARC,
    ST_WALK_EDGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                      valid;
    logic                      infeasible;
    logic signed [TOTAL_W-1:0] total_cost;
  } result_t;

endpackage

// ----- rtl/mcba_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcba_front
// Takes edge commands, clamps the weight to the cost range and packs an
// entry for the queue. Holds busy from the closing edge until its result.
// ----------------------------------------------------------------------------
module mcba_front #(
  parameter int COST_WIDTH = mcba_pkg::DEF_COST_WIDTH,
  parameter int ENTRY_W    = 2 * mcba_pkg::IDX_IN_W + COST_WIDTH + 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mcba_pkg::IDX_IN_W-1:0]         in_edge_worker,
  input  logic [mcba_pkg::IDX_IN_W-1:0]         in_edge_job,
  input  logic signed [mcba_pkg::WEIGHT_IN_W-1:0] in_edge_weight,
  input  logic                                  in_last_edge,
  input  mcba_pkg::result_t                     res_i,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [ENTRY_W-1:0]                    q_data
);

  localparam logic signed [63:0] W_HI = (64'sd1 <<< (COST_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] W_LO = -W_HI - 64'sd1;

  logic                    busy_r, busy_nxt;
  logic                    accept;
  logic signed [63:0]      wt_ext;
  logic [COST_WIDTH-1:0]   wt_sat;

  assign busy   = busy_r | q_full;
  assign accept = start & ~busy;
  assign wt_ext = 64'(in_edge_weight);

  always_comb begin
    if (wt_ext > W_HI) begin
      wt_sat = W_HI[COST_WIDTH-1:0];
    end else if (wt_ext < W_LO) begin
      wt_sat = W_LO[COST_WIDTH-1:0];
    end else begin
      wt_sat = wt_ext[COST_WIDTH-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept && in_last_edge) begin
      busy_nxt = 1'b1;
    end else if (res_i.valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign q_push = accept;
  assign q_data = {in_edge_worker, in_edge_job, wt_sat, in_last_edge};

endmodule

// ----- rtl/mcba_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcba_queue
// Small FIFO between the command front and the solver.
// ----------------------------------------------------------------------------
module mcba_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mcba_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty,
  output logic              full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/mcba_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcba_back
// Stores the batch of edges, then pushes one unit of flow per worker, each
// along a Bellman-Ford shortest path over the implicit residual graph.
// ----------------------------------------------------------------------------
module mcba_back #(
  parameter int MAX_WORKERS = mcba_pkg::DEF_MAX_WORKERS,
  parameter int MAX_JOBS    = mcba_pkg::DEF_MAX_JOBS,
  parameter int MAX_EDGES   = mcba_pkg::DEF_MAX_EDGES,
  parameter int COST_WIDTH  = mcba_pkg::DEF_COST_WIDTH,
  parameter int ENTRY_W     = 2 * mcba_pkg::IDX_IN_W + COST_WIDTH + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  logic [ENTRY_W-1:0]              q_data,
  output logic                            q_pop,
  input  logic [mcba_pkg::CFG_DATA_W-1:0] worker_count,
  input  logic [mcba_pkg::CFG_DATA_W-1:0] job_count,
  output mcba_pkg::result_t               res_o
);

  localparam int IW     = mcba_pkg::IDX_IN_W;
  localparam int TW     = mcba_pkg::TOTAL_W;
  localparam int NODES  = MAX_WORKERS + MAX_JOBS + 2;
  localparam int NW     = $clog2(NODES);
  localparam int NODE_S = MAX_WORKERS + MAX_JOBS;
  localparam int NODE_T = NODE_S + 1;
  localparam int MAXWJ  = (MAX_WORKERS > MAX_JOBS) ? MAX_WORKERS : MAX_JOBS;
  localparam int MAXIDX = (MAX_EDGES > MAXWJ) ? MAX_EDGES : MAXWJ;
  localparam int IXB    = $clog2(MAXIDX + 1);
  localparam int IXW    = (IXB > mcba_pkg::CFG_DATA_W) ? IXB : mcba_pkg::CFG_DATA_W;
  localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int WAW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int JAW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int DIST_W = COST_WIDTH + 8;
  localparam int EDW    = 2 * IW + COST_WIDTH + 1;
  localparam int PVW    = 2 + IXW;

  mcba_pkg::state_t    state_r, state_nxt;
  mcba_pkg::arc_kind_t phase_r, phase_nxt;
  mcba_pkg::arc_kind_t walk_kind_r, walk_kind_nxt;

  logic [IXW-1:0] edge_cnt_r, edge_cnt_nxt;
  logic [IXW-1:0] w_eff_r, w_eff_nxt, j_eff_r, j_eff_nxt;
  logic [IXW-1:0] flow_left_r, flow_left_nxt;
  logic [IXW-1:0] idx_r, idx_nxt, walk_idx_r, walk_idx_nxt;
  logic [TW-1:0]  cost_r, cost_nxt;
  logic           changed_r, changed_nxt;
  logic           infeasible_r, infeasible_nxt;
  logic [NW-1:0]  u_r, u_nxt, v_r, v_nxt, walk_v_r, walk_v_nxt;
  logic signed [DIST_W-1:0] aw_r, aw_nxt;
  logic           cap_r, cap_nxt;
  logic           reached_r [NODES];
  logic           reached_nxt [NODES];
  logic           wused_r [MAX_WORKERS];
  logic           wused_nxt [MAX_WORKERS];
  logic           jused_r [MAX_JOBS];
  logic           jused_nxt [MAX_JOBS];

  // edge store: {worker, job, weight, flow}
  logic [EDW-1:0] edge_mem [MAX_EDGES];
  logic           edge_we, edge_re;
  logic [EAW-1:0] edge_wa, edge_ra;
  logic [EDW-1:0] edge_wd, edge_rd_r;

  logic signed [DIST_W-1:0] dist_mem [NODES];
  logic                     dist_we, dist_re;
  logic [NW-1:0]            dist_wa, dist_ra_a, dist_ra_b;
  logic signed [DIST_W-1:0] dist_wd, dist_rd_a_r, dist_rd_b_r;

  logic [PVW-1:0] prev_mem [NODES];
  logic           prev_we, prev_re;
  logic [NW-1:0]  prev_wa, prev_ra;
  logic [PVW-1:0] prev_wd, prev_rd_r;

  // queue entry fields
  logic [IW-1:0]         q_wk, q_jb;
  logic [COST_WIDTH-1:0] q_wt;
  logic                  q_last;

  // stored edge fields
  logic [IW-1:0]                e_wk, e_jb;
  logic signed [COST_WIDTH-1:0] e_wt;
  logic                         e_flow, e_ok;

  logic [IXW-1:0] sat_w, sat_j;
  logic           adv_end;
  mcba_pkg::arc_kind_t adv_phase;
  logic [IXW-1:0] adv_idx;
  logic signed [DIST_W-1:0] cand;
  logic           relax;
  mcba_pkg::arc_kind_t pv_kind;
  logic [IXW-1:0] pv_idx;

  assign q_wk   = q_data[ENTRY_W-1 -: IW];
  assign q_jb   = q_data[ENTRY_W-1-IW -: IW];
  assign q_wt   = q_data[COST_WIDTH:1];
  assign q_last = q_data[0];

  assign e_wk   = edge_rd_r[EDW-1 -: IW];
  assign e_jb   = edge_rd_r[EDW-1-IW -: IW];
  assign e_wt   = signed'(edge_rd_r[COST_WIDTH:1]);
  assign e_flow = edge_rd_r[0];
  assign e_ok   = (IXW'(e_wk) < w_eff_r) && (IXW'(e_jb) < j_eff_r);

  assign sat_w = (IXW'(worker_count) > IXW'(MAX_WORKERS)) ? IXW'(MAX_WORKERS)
                                                           : IXW'(worker_count);
  assign sat_j = (IXW'(job_count) > IXW'(MAX_JOBS)) ? IXW'(MAX_JOBS)
                                                     : IXW'(job_count);

  assign cand    = dist_rd_a_r + aw_r;
  assign relax   = cap_r && reached_r[u_r] && (!reached_r[v_r] || (dist_rd_b_r > cand));
  assign pv_kind = mcba_pkg::arc_kind_t'(prev_rd_r[PVW-1 -: 2]);
  assign pv_idx  = prev_rd_r[IXW-1:0];

  // arc sweep order: source arcs, edge pairs, sink arcs
  always_comb begin
    adv_phase = phase_r;
    adv_idx   = idx_r + IXW'(1);
    adv_end   = 1'b0;
    case (phase_r)
      mcba_pkg::ARC_SRC: begin
        if (idx_r == w_eff_r - IXW'(1)) begin
          adv_idx = '0;
          if (edge_cnt_r != '0) begin
            adv_phase = mcba_pkg::ARC_FWD;
          end else if (j_eff_r != '0) begin
            adv_phase = mcba_pkg::ARC_SNK;
          end else begin
            adv_end = 1'b1;
          end
        end
      end
      mcba_pkg::ARC_FWD: begin
        adv_phase = mcba_pkg::ARC_REV;
        adv_idx   = idx_r;
      end
      mcba_pkg::ARC_REV: begin
        if (idx_r == edge_cnt_r - IXW'(1)) begin
          adv_idx = '0;
          if (j_eff_r != '0) begin
            adv_phase = mcba_pkg::ARC_SNK;
          end else begin
            adv_end = 1'b1;
          end
        end else begin
          adv_phase = mcba_pkg::ARC_FWD;
        end
      end
      mcba_pkg::ARC_SNK: begin
        if (idx_r == j_eff_r - IXW'(1)) begin
          adv_end = 1'b1;
        end
      end
      default: adv_end = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcba_pkg::ST_LOAD: begin
        if (!q_empty && q_last) state_nxt = mcba_pkg::ST_INIT;
      end
      mcba_pkg::ST_INIT: begin
        state_nxt = (sat_w == '0) ? mcba_pkg::ST_DONE : mcba_pkg::ST_BF;
      end
      mcba_pkg::ST_BF:       state_nxt = mcba_pkg::ST_ARC_RD;
      mcba_pkg::ST_ARC_RD:   state_nxt = mcba_pkg::ST_ARC_NODE;
      mcba_pkg::ST_ARC_NODE: state_nxt = mcba_pkg::ST_ARC_EVAL;
      mcba_pkg::ST_ARC_EVAL: begin
        if (!adv_end) begin
          state_nxt = mcba_pkg::ST_ARC_RD;
        end else if (changed_r || relax) begin
          state_nxt = mcba_pkg::ST_ARC_RD;
        end else begin
          state_nxt = mcba_pkg::ST_CHECK;
        end
      end
      mcba_pkg::ST_CHECK: begin
        state_nxt = reached_r[NW'(NODE_T)] ? mcba_pkg::ST_ADD : mcba_pkg::ST_DONE;
      end
      mcba_pkg::ST_ADD:     state_nxt = mcba_pkg::ST_WALK_RD;
      mcba_pkg::ST_WALK_RD: state_nxt = mcba_pkg::ST_WALK_ARC;
      mcba_pkg::ST_WALK_ARC: begin
        case (pv_kind)
          mcba_pkg::ARC_SRC: begin
            state_nxt = (flow_left_r == IXW'(1)) ? mcba_pkg::ST_DONE : mcba_pkg::ST_BF;
          end
          mcba_pkg::ARC_SNK: state_nxt = mcba_pkg::ST_WALK_RD;
          default:           state_nxt = mcba_pkg::ST_WALK_EDGE;
        endcase
      end
      mcba_pkg::ST_WALK_EDGE: state_nxt = mcba_pkg::ST_WALK_RD;
      mcba_pkg::ST_DONE:      state_nxt = mcba_pkg::ST_LOAD;
      default:                state_nxt = mcba_pkg::ST_LOAD;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    phase_nxt      = phase_r;
    walk_kind_nxt  = walk_kind_r;
    edge_cnt_nxt   = edge_cnt_r;
    w_eff_nxt      = w_eff_r;
    j_eff_nxt      = j_eff_r;
    flow_left_nxt  = flow_left_r;
    idx_nxt        = idx_r;
    walk_idx_nxt   = walk_idx_r;
    cost_nxt       = cost_r;
    changed_nxt    = changed_r;
    infeasible_nxt = infeasible_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    walk_v_nxt     = walk_v_r;
    aw_nxt         = aw_r;
    cap_nxt        = cap_r;
    reached_nxt    = reached_r;
    wused_nxt      = wused_r;
    jused_nxt      = jused_r;

    q_pop     = 1'b0;
    edge_we   = 1'b0;
    edge_wa   = EAW'(edge_cnt_r);
    edge_wd   = {q_wk, q_jb, q_wt, 1'b0};
    edge_re   = 1'b0;
    edge_ra   = EAW'(idx_r);
    dist_we   = 1'b0;
    dist_wa   = v_r;
    dist_wd   = cand;
    dist_re   = 1'b0;
    dist_ra_a = u_nxt;
    dist_ra_b = v_nxt;
    prev_we   = 1'b0;
    prev_wa   = v_r;
    prev_wd   = {phase_r, idx_r};
    prev_re   = 1'b0;
    prev_ra   = walk_v_r;

    res_o.valid      = 1'b0;
    res_o.infeasible = infeasible_r;
    res_o.total_cost = infeasible_r ? '0 : signed'(cost_r);

    case (state_r)
      mcba_pkg::ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (edge_cnt_r < IXW'(MAX_EDGES)) begin
            edge_we      = 1'b1;
            edge_cnt_nxt = edge_cnt_r + IXW'(1);
          end
        end
      end
      mcba_pkg::ST_INIT: begin
        w_eff_nxt      = sat_w;
        j_eff_nxt      = sat_j;
        flow_left_nxt  = sat_w;
        cost_nxt       = '0;
        infeasible_nxt = 1'b0;
        for (int i = 0; i < MAX_WORKERS; i++) wused_nxt[i] = 1'b0;
        for (int i = 0; i < MAX_JOBS; i++) jused_nxt[i] = 1'b0;
      end
      mcba_pkg::ST_BF: begin
        for (int i = 0; i < NODES; i++) reached_nxt[i] = 1'b0;
        reached_nxt[NW'(NODE_S)] = 1'b1;
        dist_we     = 1'b1;
        dist_wa     = NW'(NODE_S);
        dist_wd     = '0;
        changed_nxt = 1'b0;
        phase_nxt   = mcba_pkg::ARC_SRC;
        idx_nxt     = '0;
      end
      mcba_pkg::ST_ARC_RD: begin
        edge_re = 1'b1;
      end
      mcba_pkg::ST_ARC_NODE: begin
        case (phase_r)
          mcba_pkg::ARC_SRC: begin
            u_nxt   = NW'(NODE_S);
            v_nxt   = NW'(idx_r);
            aw_nxt  = '0;
            cap_nxt = ~wused_r[idx_r[WAW-1:0]];
          end
          mcba_pkg::ARC_FWD: begin
            u_nxt   = NW'(e_wk);
            v_nxt   = NW'(MAX_WORKERS + int'(e_jb));
            aw_nxt  = DIST_W'(e_wt);
            cap_nxt = e_ok & ~e_flow;
          end
          mcba_pkg::ARC_REV: begin
            u_nxt   = NW'(MAX_WORKERS + int'(e_jb));
            v_nxt   = NW'(e_wk);
            aw_nxt  = -DIST_W'(e_wt);
            cap_nxt = e_flow;
          end
          default: begin
            u_nxt   = NW'(MAX_WORKERS + int'(idx_r));
            v_nxt   = NW'(NODE_T);
            aw_nxt  = '0;
            cap_nxt = ~jused_r[idx_r[JAW-1:0]];
          end
        endcase
        dist_re   = 1'b1;
        dist_ra_a = u_nxt;
        dist_ra_b = v_nxt;
      end
      mcba_pkg::ST_ARC_EVAL: begin
        if (relax) begin
          dist_we          = 1'b1;
          prev_we          = 1'b1;
          reached_nxt[v_r] = 1'b1;
          changed_nxt      = 1'b1;
        end
        phase_nxt = adv_phase;
        idx_nxt   = adv_idx;
        if (adv_end) begin
          // rewind the sweep to the first arc; another pass follows only if a distance changed
          changed_nxt = 1'b0;
          phase_nxt   = mcba_pkg::ARC_SRC;
          idx_nxt     = '0;
        end
      end
      mcba_pkg::ST_CHECK: begin
        infeasible_nxt = ~reached_r[NW'(NODE_T)];
        dist_re        = 1'b1;
        dist_ra_a      = NW'(NODE_T);
      end
      mcba_pkg::ST_ADD: begin
        cost_nxt   = cost_r + TW'(dist_rd_a_r);
        walk_v_nxt = NW'(NODE_T);
      end
      mcba_pkg::ST_WALK_RD: begin
        prev_re = 1'b1;
      end
      mcba_pkg::ST_WALK_ARC: begin
        walk_kind_nxt = pv_kind;
        walk_idx_nxt  = pv_idx;
        case (pv_kind)
          mcba_pkg::ARC_SRC: begin
            wused_nxt[pv_idx[WAW-1:0]] = 1'b1;
            flow_left_nxt = flow_left_r - IXW'(1);
          end
          mcba_pkg::ARC_SNK: begin
            jused_nxt[pv_idx[JAW-1:0]] = 1'b1;
            walk_v_nxt = NW'(MAX_WORKERS + int'(pv_idx));
          end
          default: begin
            edge_re = 1'b1;
            edge_ra = EAW'(pv_idx);
          end
        endcase
      end
      mcba_pkg::ST_WALK_EDGE: begin
        // flip the flow bit of the edge on the path
        edge_we = 1'b1;
        edge_wa = EAW'(walk_idx_r);
        if (walk_kind_r == mcba_pkg::ARC_FWD) begin
          edge_wd    = {e_wk, e_jb, e_wt, 1'b1};
          walk_v_nxt = NW'(e_wk);
        end else begin
          edge_wd    = {e_wk, e_jb, e_wt, 1'b0};
          walk_v_nxt = NW'(MAX_WORKERS + int'(e_jb));
        end
      end
      mcba_pkg::ST_DONE: begin
        res_o.valid  = 1'b1;
        edge_cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mcba_pkg::ST_LOAD;
      edge_cnt_r <= '0;
      flow_left_r <= '0;
      cost_r     <= '0;
      changed_r  <= 1'b0;
      infeasible_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      flow_left_r <= flow_left_nxt;
      cost_r     <= cost_nxt;
      changed_r  <= changed_nxt;
      infeasible_r <= infeasible_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r     <= phase_nxt;
    walk_kind_r <= walk_kind_nxt;
    w_eff_r     <= w_eff_nxt;
    j_eff_r     <= j_eff_nxt;
    idx_r       <= idx_nxt;
    walk_idx_r  <= walk_idx_nxt;
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    walk_v_r    <= walk_v_nxt;
    aw_r        <= aw_nxt;
    cap_r       <= cap_nxt;
    reached_r   <= reached_nxt;
    wused_r     <= wused_nxt;
    jused_r     <= jused_nxt;
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (edge_re) edge_rd_r <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (dist_re) begin
      dist_rd_a_r <= dist_mem[dist_ra_a];
      dist_rd_b_r <= dist_mem[dist_ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_r <= prev_mem[prev_ra];
  end

endmodule

// ----- rtl/min_cost_bipartite_assignment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_cost_bipartite_assignment
// Edges load one per cycle while busy is low; the closing edge starts a successive
// shortest path solve that ends in one result strobe of one cycle.
// Each Bellman-Ford pass reads every arc in turn: fetch the edge, resolve its
// nodes and read both distances, then evaluate and relax.
// busy stays high for the whole solve; the receiver cannot stall results.
// Reset is synchronous (rst_n low): control clears, both counts return to 1.
// ----------------------------------------------------------------------------
module min_cost_bipartite_assignment #(
  parameter int MAX_WORKERS = mcba_pkg::DEF_MAX_WORKERS,
  parameter int MAX_JOBS    = mcba_pkg::DEF_MAX_JOBS,
  parameter int MAX_EDGES   = mcba_pkg::DEF_MAX_EDGES,
  parameter int COST_WIDTH  = mcba_pkg::DEF_COST_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [mcba_pkg::IDX_IN_W-1:0]           in_edge_worker,
  input  logic [mcba_pkg::IDX_IN_W-1:0]           in_edge_job,
  input  logic signed [mcba_pkg::WEIGHT_IN_W-1:0] in_edge_weight,
  input  logic                                    in_last_edge,
  output logic                                    out_valid,
  output logic signed [mcba_pkg::TOTAL_W-1:0]     out_total_cost,
  output logic                                    out_infeasible,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mcba_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [mcba_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int ENTRY_W = 2 * mcba_pkg::IDX_IN_W + COST_WIDTH + 1;

  logic [mcba_pkg::CFG_DATA_W-1:0] worker_count_r, worker_count_nxt;
  logic [mcba_pkg::CFG_DATA_W-1:0] job_count_r, job_count_nxt;
  logic                 q_push, q_pop, q_empty, q_full;
  logic [ENTRY_W-1:0]   q_in, q_out;
  mcba_pkg::result_t    res;

  assign cfg_ready = 1'b1;

  always_comb begin
    worker_count_nxt = worker_count_r;
    job_count_nxt    = job_count_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mcba_pkg::CFG_WORKER_COUNT: worker_count_nxt = cfg_data;
        mcba_pkg::CFG_JOB_COUNT:    job_count_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= mcba_pkg::CFG_COUNT_RESET;
      job_count_r    <= mcba_pkg::CFG_COUNT_RESET;
    end else begin
      worker_count_r <= worker_count_nxt;
      job_count_r    <= job_count_nxt;
    end
  end

  mcba_front #(
    .COST_WIDTH (COST_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_edge_worker (in_edge_worker),
    .in_edge_job    (in_edge_job),
    .in_edge_weight (in_edge_weight),
    .in_last_edge   (in_last_edge),
    .res_i          (res),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  mcba_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (mcba_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  mcba_back #(
    .MAX_WORKERS (MAX_WORKERS),
    .MAX_JOBS    (MAX_JOBS),
    .MAX_EDGES   (MAX_EDGES),
    .COST_WIDTH  (COST_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .worker_count (worker_count_r),
    .job_count    (job_count_r),
    .res_o        (res)
  );

  assign out_valid      = res.valid;
  assign out_total_cost = res.total_cost;
  assign out_infeasible = res.infeasible;

endmodule

// ----- rtl/mcba_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcba_checker
// Port-level checks on the solver: busy framing of a solve, the shape of the
// result strobe and a zero total cost on an infeasible result.
// ----------------------------------------------------------------------------
`include "min_cost_bipartite_assignment_macros.svh"

module mcba_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    start,
  input logic                                    busy,
  input logic                                    in_last_edge,
  input logic                                    out_valid,
  input logic signed [mcba_pkg::TOTAL_W-1:0]     out_total_cost,
  input logic                                    out_infeasible
);

  `MCBA_ASSERT_NEXT(a_last_sets_busy, start && !busy && in_last_edge, busy)
  `MCBA_ASSERT_NOW(a_result_while_busy, out_valid, busy)
  `MCBA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `MCBA_ASSERT_NOW(a_infeasible_zero, out_valid && out_infeasible, out_total_cost == '0)

endmodule

bind min_cost_bipartite_assignment mcba_checker u_mcba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_last_edge   (in_last_edge),
  .out_valid      (out_valid),
  .out_total_cost (out_total_cost),
  .out_infeasible (out_infeasible)
);
